FILE: src/fdl_pkg.sv
// Shared constants for the fractional delay line: field widths and buffering depth.
package fdl_pkg;

   localparam int SAMPLE_W = 24;
   localparam int DELAY_W = 32;
   localparam int FRAC_W = 16;
   localparam int DELAY_INT_W = DELAY_W - FRAC_W;
   localparam int REQ_DATA_W = SAMPLE_W + DELAY_W;
   localparam int RSP_DATA_W = SAMPLE_W;
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

endpackage

FILE: src/fractional_delay_line.sv
// Top level of the per-channel fractional delay line with linear interpolation.
//
// Usage: each req transaction carries a channel in req_tuser and, in req_tdata, a signed
// Q1.23 sample and an unsigned Q16.16 delay. For each one the block returns on rsp one
// Q1.23 sample: the channel's history read (write position - delay) samples back, with
// the two neighboring stored samples blended by the delay fraction and floored. The
// incoming sample is then stored and the channel's write position advances.
// The sample store is a single RAM with one read port, and each item needs two reads (the
// two neighbors) on it; req_tready drops for the cycle after every accepted transaction.
// Reset: synchronous, active high; clears write positions and per-channel fill flags.
// The store itself is not swept: an entry that was never written since reset is masked
// to zero by comparing it with the write position, so the block is ready at once.
// Stall: up to 8 results queue in an output FIFO while rsp_tready is low; req_tready
// stays low while 8 transactions are accepted but not yet delivered.
module fractional_delay_line #(
   parameter int BUFFER_DEPTH = 65536,
   parameter int CHANNELS = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [23:0] sample_in, [55:24] delay_samples
   input  logic [fdl_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] channel
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [23:0] sample_out
   output logic [fdl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import fdl_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MEM_DEPTH = CHANNELS * (2 ** AW);
   localparam int MEM_AW = $clog2(MEM_DEPTH);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUFFER_DEPTH);

   // Handshake and per-channel write state
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 gap_ff;
   logic [OUT_CNT_W-1:0] pend_ff;
   logic [OUT_CNT_W-1:0] pend_in;
   logic [CHW-1:0]       ch_sel;
   logic [AW-1:0]        wp_ff [CHANNELS];
   logic [AW-1:0]        wp_in [CHANNELS];
   logic                 full_ff [CHANNELS];
   logic                 full_in [CHANNELS];
   logic [AW-1:0]        wp_cur;
   logic                 wp_wrap;

   // Pipeline valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;

   // Stage payloads
   logic [CHW-1:0]              ch1_ff, ch2_ff, ch3_ff, ch4_ff, ch5_ff, ch6_ff;
   logic [SAMPLE_W-1:0]         x1_ff, x2_ff, x3_ff, x4_ff, x5_ff, x6_ff;
   logic [AW-1:0]               wp1_ff, wp2_ff, wp3_ff, wp4_ff, wp5_ff, wp6_ff;
   logic                        full1_ff, full2_ff, full3_ff, full4_ff, full5_ff, full6_ff;
   logic [FRAC_W-1:0]           frac1_ff, frac2_ff, frac3_ff, frac4_ff;
   logic [DELAY_INT_W-1:0]      dint1_ff, dint2_ff, dint3_ff;
   logic [DELAY_INT_W-1:0]      q2_ff;
   logic [DELAY_INT_W-1:0]      qd3_ff;
   logic [AW-1:0]               dm4_ff;
   logic [AW-1:0]               ip5_ff;
   logic [FRAC_W-1:0]           f5_ff, f6_ff, f7_ff, f8_ff;
   logic [AW-1:0]               nx6_ff;
   logic                        okp6_ff;
   logic                        okn7_ff;
   logic signed [SAMPLE_W-1:0]  prev7_ff, prev8_ff, prev9_ff;
   logic signed [SAMPLE_W:0]    diff8_ff;
   logic signed [SAMPLE_W+FRAC_W+1:0] prod9_ff;

   // Stage logic
   logic [47:0]                 recip_prod;
   logic [31:0]                 qd_full;
   logic [DELAY_INT_W:0]        rem_raw;
   logic [DELAY_INT_W:0]        rem_fix;
   logic [AW+1:0]               pos_raw;
   logic [AW+1:0]               pos_fix;
   logic [AW-1:0]               nx_in;
   logic signed [SAMPLE_W-1:0]  ram_val;
   logic signed [SAMPLE_W-1:0]  next_val;
   logic signed [SAMPLE_W:0]    diff_in;
   logic signed [SAMPLE_W+FRAC_W+1:0] prod_in;
   logic [SAMPLE_W-1:0]         y_in;

   // Memory ports
   logic [CHW+AW-1:0]   rd_full;
   logic [CHW+AW-1:0]   wr_full;
   logic [MEM_AW-1:0]   mem_rd_addr;
   logic [MEM_AW-1:0]   mem_wr_addr;
   logic [SAMPLE_W-1:0] mem_rd_data;

   // Output FIFO
   logic [RSP_DATA_W-1:0] fifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]  fifo_wr_ff;
   logic [OUT_PTR_W-1:0]  fifo_rd_ff;
   logic [OUT_CNT_W-1:0]  fifo_cnt_ff;

   assign req_tready = !gap_ff && (pend_ff < OUT_CNT_W'(OUT_DEPTH));
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign ch_sel = (CHANNELS > 1) ? CHW'(req_tuser) : '0;

   assign wp_cur = wp_ff[ch_sel];
   assign wp_wrap = (wp_cur == AW'(BUFFER_DEPTH - 1));

   always_comb begin
      wp_in = wp_ff;
      full_in = full_ff;
      if (req_fire) begin
         wp_in[ch_sel] = wp_wrap ? '0 : wp_cur + AW'(1);
         if (wp_wrap) begin
            full_in[ch_sel] = 1'b1;
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + OUT_CNT_W'(1);
      end else if (!req_fire && rsp_fire) begin
         pend_in = pend_ff - OUT_CNT_W'(1);
      end
   end

   // Remainder of the integer delay by the depth: reciprocal estimate, then one correction.
   assign recip_prod = 48'(dint1_ff) * 48'(RECIP);
   assign qd_full = 32'(q2_ff) * 32'(BUFFER_DEPTH);
   assign rem_raw = {1'b0, dint3_ff} - {1'b0, qd3_ff};
   assign rem_fix = (32'(rem_raw) >= 32'(BUFFER_DEPTH)) ?
                    rem_raw - (DELAY_INT_W + 1)'(BUFFER_DEPTH) : rem_raw;

   // A nonzero fraction borrows one whole sample from the integer read position.
   assign pos_raw = {2'b00, wp4_ff} - {2'b00, dm4_ff} - (AW + 2)'(frac4_ff != '0);
   assign pos_fix = pos_raw[AW+1] ? pos_raw + (AW + 2)'(BUFFER_DEPTH) : pos_raw;

   assign nx_in = (ip5_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : ip5_ff + AW'(1);

   // Entries not yet written since reset read as zero.
   assign ram_val = mem_rd_data;
   assign next_val = okn7_ff ? ram_val : '0;
   assign diff_in = {next_val[SAMPLE_W-1], next_val} - {prev7_ff[SAMPLE_W-1], prev7_ff};
   assign prod_in = diff8_ff * $signed({1'b0, f8_ff});
   assign y_in = prev9_ff + prod9_ff[SAMPLE_W+FRAC_W-1:FRAC_W];

   // The two reads of one item never overlap those of the next, so one port serves both.
   assign rd_full = v6_ff ? {ch6_ff, nx6_ff} : {ch5_ff, ip5_ff};
   assign wr_full = {ch6_ff, wp6_ff};
   assign mem_rd_addr = rd_full[MEM_AW-1:0];
   assign mem_wr_addr = wr_full[MEM_AW-1:0];

   fdl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (v6_ff),
      .wr_addr (mem_wr_addr),
      .wr_data (x6_ff),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 1'b0;
         pend_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         fifo_wr_ff <= '0;
         fifo_rd_ff <= '0;
         fifo_cnt_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i] <= '0;
            full_ff[i] <= 1'b0;
         end
      end else begin
         gap_ff <= req_fire;
         pend_ff <= pend_in;
         v1_ff <= req_fire;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
         wp_ff <= wp_in;
         full_ff <= full_in;
         if (v9_ff) begin
            fifo_wr_ff <= fifo_wr_ff + OUT_PTR_W'(1);
         end
         if (rsp_fire) begin
            fifo_rd_ff <= fifo_rd_ff + OUT_PTR_W'(1);
         end
         if (v9_ff && !rsp_fire) begin
            fifo_cnt_ff <= fifo_cnt_ff + OUT_CNT_W'(1);
         end else if (!v9_ff && rsp_fire) begin
            fifo_cnt_ff <= fifo_cnt_ff - OUT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      ch1_ff <= ch_sel;
      x1_ff <= req_tdata[SAMPLE_W-1:0];
      frac1_ff <= req_tdata[SAMPLE_W+FRAC_W-1:SAMPLE_W];
      dint1_ff <= req_tdata[REQ_DATA_W-1:SAMPLE_W+FRAC_W];
      wp1_ff <= wp_cur;
      full1_ff <= full_ff[ch_sel];

      ch2_ff <= ch1_ff;
      x2_ff <= x1_ff;
      frac2_ff <= frac1_ff;
      dint2_ff <= dint1_ff;
      wp2_ff <= wp1_ff;
      full2_ff <= full1_ff;
      q2_ff <= recip_prod[47:32];

      ch3_ff <= ch2_ff;
      x3_ff <= x2_ff;
      frac3_ff <= frac2_ff;
      dint3_ff <= dint2_ff;
      wp3_ff <= wp2_ff;
      full3_ff <= full2_ff;
      qd3_ff <= qd_full[DELAY_INT_W-1:0];

      ch4_ff <= ch3_ff;
      x4_ff <= x3_ff;
      frac4_ff <= frac3_ff;
      wp4_ff <= wp3_ff;
      full4_ff <= full3_ff;
      dm4_ff <= AW'(rem_fix);

      ch5_ff <= ch4_ff;
      x5_ff <= x4_ff;
      wp5_ff <= wp4_ff;
      full5_ff <= full4_ff;
      ip5_ff <= pos_fix[AW-1:0];
      f5_ff <= FRAC_W'(0) - frac4_ff;

      ch6_ff <= ch5_ff;
      x6_ff <= x5_ff;
      wp6_ff <= wp5_ff;
      full6_ff <= full5_ff;
      f6_ff <= f5_ff;
      nx6_ff <= nx_in;
      okp6_ff <= full5_ff || (ip5_ff < wp5_ff);

      prev7_ff <= okp6_ff ? ram_val : '0;
      f7_ff <= f6_ff;
      okn7_ff <= full6_ff || (nx6_ff < wp6_ff);

      prev8_ff <= prev7_ff;
      diff8_ff <= diff_in;
      f8_ff <= f7_ff;

      prev9_ff <= prev8_ff;
      prod9_ff <= prod_in;

      if (v9_ff) begin
         fifo_ff[fifo_wr_ff] <= y_in;
      end
   end

   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tdata = fifo_ff[fifo_rd_ff];

endmodule

FILE: src/fdl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module fdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the entry written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fdl_checker.sv
// Port-level checker for the fractional delay line, bound to the top level.
module fdl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fdl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import fdl_pkg::*;

   logic [OUT_CNT_W:0] outst_ff;
   logic               req_fire;
   logic               rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Transactions accepted on req but not yet answered on rsp.
   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         outst_ff <= outst_ff + (OUT_CNT_W + 1)'(1);
      end else if (!req_fire && rsp_fire) begin
         outst_ff <= outst_ff - (OUT_CNT_W + 1)'(1);
      end
   end

   a_issue_spacing: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("req_tready high in the cycle after an accepted transaction");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (outst_ff != '0))
      else $error("rsp_tvalid without an outstanding request");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= (OUT_CNT_W + 1)'(OUT_DEPTH))
      else $error("more transactions outstanding than the output queue holds");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed or dropped");

endmodule

bind fractional_delay_line fdl_checker u_fdl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/fractional_delay_line_tb.sv
// Self-checking testbench for the fractional delay line: predicted interpolated samples vs. rsp.
module fractional_delay_line_tb;
   import fdl_pkg::*;

   localparam int DEPTH = 65536;
   localparam int NUM_CH = 2;
   localparam int HALF_PERIOD = 6;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic                channel;
      logic [SAMPLE_W-1:0] sample;
      logic [DELAY_W-1:0]  delay;
   } delay_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Model of the delay line contents and per-channel write positions.
   logic signed [SAMPLE_W-1:0] history [NUM_CH][DEPTH];
   int unsigned                write_pos [NUM_CH];

   delay_item_type        pending_items [$];
   logic [RSP_DATA_W-1:0] expected_samples [$];
   int unsigned           items_queued = 0;
   int unsigned           results_checked = 0;
   int unsigned           mismatches = 0;
   logic                  req_taken = 1'b0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;

   fractional_delay_line #(
      .BUFFER_DEPTH(DEPTH),
      .CHANNELS(NUM_CH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Reads the interpolated sample for one item, then stores the item and advances the channel.
   function automatic logic [RSP_DATA_W-1:0] interpolate_and_store(
      input logic ch,
      input logic [SAMPLE_W-1:0] sample,
      input logic [DELAY_W-1:0] delay
   );
      longint unsigned span;
      longint unsigned pos;
      int unsigned     wp;
      int unsigned     ip;
      int unsigned     ip_next;
      longint          frac;
      longint          prev;
      longint          next;
      longint          acc;
      wp = write_pos[ch];
      span = longint'(DEPTH) << FRAC_W;
      pos = ((longint'(wp) << FRAC_W) + span - (longint'(delay) % span)) % span;
      ip = int'(pos >> FRAC_W);
      frac = longint'(pos & ((64'd1 << FRAC_W) - 1));
      ip_next = (ip + 1) % DEPTH;
      prev = history[ch][ip];
      next = history[ch][ip_next];
      acc = prev * ((longint'(1) << FRAC_W) - frac) + next * frac;
      history[ch][wp] = $signed(sample);
      wp = wp + 1;
      if (wp >= DEPTH) begin
         wp = 0;
      end
      write_pos[ch] = wp;
      // An arithmetic shift floors toward minus infinity.
      return RSP_DATA_W'(acc >>> FRAC_W);
   endfunction

   task automatic note_mismatch(input string what, input logic [RSP_DATA_W-1:0] want,
                                input logic [RSP_DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
         $display("Mismatch (%s) at %0t: expected %h, got %h", what, $time, want, got);
      end
   endtask

   task automatic queue_item(input logic ch, input logic [SAMPLE_W-1:0] sample,
                             input logic [DELAY_W-1:0] delay);
      delay_item_type item;
      item.channel = ch;
      item.sample = sample;
      item.delay = delay;
      pending_items.push_back(item);
      items_queued++;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] extremes [4];
      extremes = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
      if ($urandom_range(99) < 10) begin
         return extremes[$urandom_range(3)];
      end
      return SAMPLE_W'($urandom);
   endfunction

   // Mostly short delays so that reads land on recently written history.
   function automatic logic [DELAY_W-1:0] random_delay();
      logic [FRAC_W-1:0] edge_fracs [4];
      int unsigned       pick;
      edge_fracs = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
      pick = $urandom_range(99);
      if (pick < 60) begin
         return {16'($urandom_range(48)), 16'($urandom)};
      end else if (pick < 75) begin
         return {16'($urandom_range(48)), 16'h0000};
      end else if (pick < 82) begin
         return {16'($urandom_range(48)), edge_fracs[$urandom_range(3)]};
      end else if (pick < 95) begin
         return $urandom;
      end
      return {16'hFFFF - 16'($urandom_range(8)), 16'($urandom)};
   endfunction

   always @(negedge clock) begin : drive
      delay_item_type item;
      int             burst_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_items.size() > 0 &&
                (burst_left > 0 || $urandom_range(99) >= send_idle_pct)) begin
               item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {item.delay, item.sample};
               req_tuser <= item.channel;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= burst_left > 0 || $urandom_range(99) >= recv_idle_pct;
         // Now and then both sides run flat out for a while.
         if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(99) < 2) begin
            burst_left = $urandom_range(60, 20);
         end
      end
   end

   always @(posedge clock) begin : observe
      logic [RSP_DATA_W-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(interpolate_and_store(req_tuser,
               req_tdata[SAMPLE_W-1:0], req_tdata[REQ_DATA_W-1:SAMPLE_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               note_mismatch("unexpected transaction", '0, rsp_tdata);
            end else begin
               want = expected_samples.pop_front();
               results_checked++;
               if (rsp_tdata !== want) begin
                  note_mismatch("sample_out", want, rsp_tdata);
               end
            end
         end
      end
   end

   initial begin
      #(24_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      for (int c = 0; c < NUM_CH; c++) begin
         write_pos[c] = 0;
         for (int i = 0; i < DEPTH; i++) begin
            history[c][i] = '0;
         end
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fresh store, zero delay, whole and half steps, extreme samples and fractions.
      send_idle_pct = 11;
      recv_idle_pct = 53;
      queue_item(1'b0, 24'h7FFFFF, 32'h0000_0000);
      queue_item(1'b0, 24'h800000, 32'h0001_0000);
      queue_item(1'b0, 24'h123456, 32'h0001_0000);
      queue_item(1'b0, 24'h7FFFFF, 32'h0001_8000);
      queue_item(1'b0, 24'h800000, 32'h0001_8000);
      queue_item(1'b0, 24'h000001, 32'h0001_8000);
      queue_item(1'b0, 24'hFFFFFF, 32'h0001_0001);
      queue_item(1'b0, 24'h000000, 32'h0001_FFFF);
      queue_item(1'b0, 24'h555555, 32'hFFFF_FFFF);
      queue_item(1'b0, 24'hAAAAAA, 32'h0000_8000);
      queue_item(1'b0, 24'h400000, 32'h0003_0000);
      queue_item(1'b0, 24'hC00000, 32'h0000_0001);
      queue_item(1'b1, 24'h800000, 32'h0000_0000);
      queue_item(1'b1, 24'h7FFFFF, 32'h0001_0000);
      queue_item(1'b1, 24'h800000, 32'h0001_8000);
      queue_item(1'b1, 24'h7FFFFF, 32'h0001_4000);
      queue_item(1'b1, 24'h000000, 32'h0002_C000);
      queue_item(1'b1, 24'hFFFFFF, 32'hFFFF_0000);
      queue_item(1'b1, 24'h000000, 32'h5555_AAAA);
      queue_item(1'b0, 24'h3C3C3C, 32'hAAAA_5555);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 11 : 0;
         for (int i = 0; i < 560; i++) begin
            queue_item(1'($urandom), random_sample(), random_delay());
         end
         while (results_checked != items_queued) @(negedge clock);
      end

      // Delays at the ends of their range on alternating channels.
      for (int i = 0; i < 80; i++) begin
         case ($urandom_range(3))
            0: queue_item(1'(i), random_sample(), 32'h0000_0000);
            1: queue_item(1'(i), random_sample(), 32'hFFFF_0000);
            2: queue_item(1'(i), random_sample(), 32'hFFFF_FFFF);
            default: queue_item(1'(i), random_sample(), 32'h0000_0001);
         endcase
      end
      while (results_checked != items_queued) @(negedge clock);

      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
